@@ hdl/ehd_pkg.sv @@
// Shared constants, types and register codes for the error-diffusion halftone core.
// No dependencies; compiled first.
package ehd_pkg;

    // Geometry and number format
    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_CHANNELS = 3;
    localparam int FRAC_BITS    = 8;
    localparam int ERR_BITS     = FRAC_BITS + 10;

    // Fixed field widths
    localparam int SAMPLE_W   = 8;
    localparam int SAMPLE_MAX = 255;
    localparam int LW_W       = 11;
    localparam int NCH_W      = 2;
    localparam int CFG_W      = LW_W;
    localparam int CFG_IDX_W  = 1;

    // Counter and index widths
    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CH_IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    // Register reset values
    localparam int LW_RESET  = 512;
    localparam int NCH_RESET = 1;

    // Diffusion weights, in sixteenths
    localparam int         SHARE_SHIFT = 4;
    localparam logic [2:0] W_RIGHT     = 3'd7;
    localparam logic [2:0] W_DIAG_L    = 3'd3;
    localparam logic [2:0] W_BELOW     = 3'd5;
    localparam logic [2:0] W_DIAG_R    = 3'd1;

    // Front-to-back queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINE_WIDTH = 1'b0,
        REG_CHANNELS   = 1'b1
    } t_cfg_idx;

    // One classified sample, front to back
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                frame_start;
        logic                first_row;
        logic                last_col;
        logic [COL_W-1:0]    col;
        logic [CH_IW-1:0]    ch;
    } t_op;

endpackage

@@ hdl/ehd_if.sv @@
// Stream interfaces for the halftone core: sample input and dot output.
// Depends on ehd_pkg.
interface ehd_in_if;
    import ehd_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic                frame_start;

    modport source (output valid, output sample, output frame_start, input ready);
    modport sink   (input valid, input sample, input frame_start, output ready);
endinterface

interface ehd_out_if;
    logic valid;
    logic ready;
    logic dot;

    modport source (output valid, output dot, input ready);
    modport sink   (input valid, input dot, output ready);
endinterface

@@ hdl/error_diffusion_halftone_core.sv @@
// Floyd-Steinberg error-diffusion halftoner. Takes one 8-bit sample beat per clock, raster
// order, channels interleaved, frame_start on the first sample of an image, and returns one
// dot beat per sample (1 = full on, 0 = off) in the same order. Each sample plus its diffused
// error (8 fractional bits) is compared with mid-grey 127.5; the error goes 7/16 right and
// 3/16, 5/16, 1/16 to the next row, each share rounded toward minus infinity, every stored
// error saturated to 18 signed bits, and error falling outside the image dropped. Rate: one
// sample per clock while the output is taken. The one exception is very short rows: when
// (line_width-1)*channels is 1 or 2, or line_width is 1 with fewer than three channels,
// a sample whose line-buffer entry is still being written by one of the two samples ahead
// of it waits for that write, which lowers the rate.
// An accepted beat passes the queue, registers r_b1 and r_b2, then the dot register r_dot.
// A 4-entry queue sits between the front end (counters and classification) and the back
// end, so the input keeps being accepted while a dot waits, until the queue is full.
// The line buffer is two 1536 x 18 memories split by column parity; its contents after reset
// are unspecified and need no clearing pass, since the first row of a frame never reads it.
// Registers (write only, take effect for the next sample): index 0 line_width (pixels per
// row, reset 512; 0 acts as 1, above 1024 acts as 1024), index 1 channels (reset 1; 0 acts
// as 1, 3 max). Write them only while the core is idle; shrinking a row mid-frame ends the
// current row at the new limit.
// Depends on ehd_pkg, ehd_if, ehd_front, ehd_queue and ehd_back.
module error_diffusion_halftone_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ehd_in_if.sink                        i_in,
    ehd_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [ehd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ehd_pkg::CFG_W-1:0]     i_cfg_data
);
    import ehd_pkg::*;

    // front -> queue
    logic q_push;
    t_op  q_in_op;
    logic q_full;

    // queue -> back
    logic q_vld;
    logic q_pop;
    t_op  q_head;

    // Front end: holds the registers and the raster position, tags each sample with
    // its column, channel, row-end and first-row flags.
    ehd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_op     (q_in_op)
    );

    // Decoupling queue: input ready only depends on its fill level.
    ehd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (q_in_op),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_vld   (q_vld),
        .o_head  (q_head)
    );

    // Back end: buffer read, quantize and right carry, next-row shares and buffer
    // writes, then the registered dot beat.
    ehd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q_vld (q_vld),
        .i_q_op  (q_head),
        .o_q_pop (q_pop),
        .o_out   (o_out)
    );

endmodule

@@ hdl/ehd_front.sv @@
// Front end: config registers, raster counters, and classification of each sample beat.
// Depends on ehd_pkg and ehd_if.
module ehd_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    ehd_in_if.sink                       i_in,
    input  logic                         i_cfg_we,
    input  logic [ehd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ehd_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                         i_q_full,
    output logic                         o_q_push,
    output ehd_pkg::t_op                 o_q_op
);
    import ehd_pkg::*;

    localparam int CMPW  = (COL_W + 1 > LW_W) ? COL_W + 1 : LW_W;
    localparam int NCMPW = 3;

    logic [LW_W-1:0]  r_line_width;
    logic [NCH_W-1:0] r_channels;
    logic [COL_W-1:0] r_col, n_col;
    logic [CH_IW-1:0] r_ch, n_ch;
    logic             r_first, n_first;

    logic [CMPW-1:0]  w_eff;
    logic [NCMPW-1:0] n_eff;
    logic [COL_W-1:0] col_cur;
    logic [CH_IW-1:0] ch_cur;
    logic             first_cur;
    logic             last_col;
    logic             last_ch;
    logic             accept;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LW_W'(LW_RESET);
            r_channels   <= NCH_W'(NCH_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LINE_WIDTH: r_line_width <= i_cfg_data;
                REG_CHANNELS:   r_channels   <= i_cfg_data[NCH_W-1:0];
                default: ;
            endcase
        end
    end

    // effective limits: zero acts as one, oversize clamps
    always_comb begin
        if (r_line_width == '0) begin
            w_eff = CMPW'(1);
        end else if (CMPW'(r_line_width) > CMPW'(MAX_WIDTH)) begin
            w_eff = CMPW'(MAX_WIDTH);
        end else begin
            w_eff = CMPW'(r_line_width);
        end
        if (r_channels == '0) begin
            n_eff = NCMPW'(1);
        end else if (NCMPW'(r_channels) > NCMPW'(MAX_CHANNELS)) begin
            n_eff = NCMPW'(MAX_CHANNELS);
        end else begin
            n_eff = NCMPW'(r_channels);
        end
    end

    assign accept    = i_in.valid && i_in.ready;
    assign i_in.ready = !i_q_full;

    // frame start restarts the raster position before this beat is classified
    assign col_cur   = i_in.frame_start ? '0 : r_col;
    assign ch_cur    = i_in.frame_start ? '0 : r_ch;
    assign first_cur = i_in.frame_start ? 1'b1 : r_first;
    assign last_col  = (CMPW'(col_cur) + CMPW'(1)) >= w_eff;
    assign last_ch   = (NCMPW'(ch_cur) + NCMPW'(1)) >= n_eff;

    always_comb begin
        n_col   = col_cur;
        n_ch    = ch_cur + CH_IW'(1);
        n_first = first_cur;
        if (last_ch) begin
            n_ch = '0;
            if (last_col) begin
                n_col   = '0;
                n_first = 1'b0;
            end else begin
                n_col = col_cur + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_ch    <= '0;
            r_first <= 1'b1;
        end else if (accept) begin
            r_col   <= n_col;
            r_ch    <= n_ch;
            r_first <= n_first;
        end
    end

    assign o_q_push           = accept;
    assign o_q_op.sample      = i_in.sample;
    assign o_q_op.frame_start = i_in.frame_start;
    assign o_q_op.first_row   = first_cur;
    assign o_q_op.last_col    = last_col;
    assign o_q_op.col         = col_cur;
    assign o_q_op.ch          = ch_cur;

endmodule

@@ hdl/ehd_queue.sv @@
// Short FIFO of classified samples between the front end and the diffusion back end.
// Depends on ehd_pkg.
module ehd_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  ehd_pkg::t_op i_op,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_vld,
    output ehd_pkg::t_op o_head
);
    import ehd_pkg::*;

    t_op               r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign o_full = (r_count == (QPTR_W + 1)'(QDEPTH));
    assign o_vld  = (r_count != '0);
    assign o_head = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= bump(r_wr_ptr);
            if (i_pop)  r_rd_ptr <= bump(r_rd_ptr);
            if (i_push && !i_pop) begin
                r_count <= r_count + (QPTR_W + 1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (QPTR_W + 1)'(1);
            end
        end
    end

endmodule

@@ hdl/ehd_back.sv @@
// Diffusion back end: line-buffer banks, quantizer, error shares and output register.
// Depends on ehd_pkg and ehd_if.
module ehd_back (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_q_vld,
    input  ehd_pkg::t_op i_q_op,
    output logic         o_q_pop,
    ehd_out_if.source    o_out
);
    import ehd_pkg::*;

    localparam int VW         = ERR_BITS + 2;
    localparam int HALF_W     = (MAX_WIDTH + 1) / 2;
    localparam int BANK_DEPTH = HALF_W * MAX_CHANNELS;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    typedef logic signed [ERR_BITS-1:0] t_err;

    localparam logic signed [VW-1:0] ERR_HI = VW'(2 ** (ERR_BITS - 1) - 1);
    localparam logic signed [VW-1:0] ERR_LO = ~ERR_HI;
    localparam logic signed [VW-1:0] DOT_TH = VW'(SAMPLE_MAX * 2 ** (FRAC_BITS - 1));
    localparam logic signed [VW-1:0] FULL   = VW'(SAMPLE_MAX * 2 ** FRAC_BITS);

    function automatic t_err sat(input logic signed [VW-1:0] x);
        if (x > ERR_HI) return ERR_HI[ERR_BITS-1:0];
        if (x < ERR_LO) return ERR_LO[ERR_BITS-1:0];
        return x[ERR_BITS-1:0];
    endfunction

    // floor(e * wt / 16)
    function automatic t_err share(input t_err e, input logic [2:0] wt);
        logic signed [ERR_BITS+3:0] p;
        p = (ERR_BITS + 4)'(e) * $signed({1'b0, wt});
        return p[ERR_BITS+SHARE_SHIFT-1:SHARE_SHIFT];
    endfunction

    function automatic logic [BANK_AW-1:0] bank_addr(input logic [COL_W-1:0] col,
                                                     input logic [CH_IW-1:0] ch);
        return BANK_AW'((col >> 1) * MAX_CHANNELS + ch);
    endfunction

    // true when stage item s still has to write the entry that h reads
    function automatic logic hits(input t_op s, input t_op h);
        return (s.ch == h.ch) &&
               (((s.col != '0) && (s.col == h.col + COL_W'(1))) ||
                (s.last_col && (s.col == h.col)));
    endfunction

    // line buffer, split by column parity so a row end can write two entries
    logic [ERR_BITS-1:0] r_bank0 [BANK_DEPTH];
    logic [ERR_BITS-1:0] r_bank1 [BANK_DEPTH];
    logic [ERR_BITS-1:0] r_rd0, r_rd1;

    logic                                    r_b1_vld, r_b2_vld, r_out_vld;
    t_op                                     r_b1, r_b2;
    t_err                                    r_b2_e;
    logic                                    r_b2_dot, r_dot;
    logic [MAX_CHANNELS-1:0][ERR_BITS-1:0]   r_carry, n_carry;
    logic [MAX_CHANNELS-1:0][ERR_BITS-1:0]   r_p0, n_p0;
    logic [MAX_CHANNELS-1:0][ERR_BITS-1:0]   r_p1, n_p1;

    logic               adv, hazard, take;
    logic [BANK_AW-1:0] rd_addr;

    // stage 1
    t_err                   carry_in, below, e_b1, carry_new;
    logic signed [VW-1:0]   s_w, c_w, b_w, v, ev;
    logic                   dot_b1;

    // stage 2
    t_err               p0_old, p1_old, e3, e5, e1, wr_prev_data, np0;
    logic [COL_W-1:0]   col_p;
    logic               prev_en, do_b2;
    logic               we0, we1;
    logic [BANK_AW-1:0] wa0, wa1;
    t_err               wd0, wd1;

    assign adv    = !r_out_vld || o_out.ready;
    assign hazard = !i_q_op.first_row &&
                    ((r_b1_vld && hits(r_b1, i_q_op)) || (r_b2_vld && hits(r_b2, i_q_op)));
    assign take    = adv && i_q_vld && !hazard;
    assign o_q_pop = take;
    assign rd_addr = bank_addr(i_q_op.col, i_q_op.ch);

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_rd0 <= r_bank0[rd_addr];
            r_rd1 <= r_bank1[rd_addr];
        end
        if (we0) r_bank0[wa0] <= wd0;
        if (we1) r_bank1[wa1] <= wd1;
    end

    // stage 1: quantize, next right carry
    always_comb begin
        carry_in = r_b1.frame_start ? '0 : t_err'(r_carry[r_b1.ch]);
        if (r_b1.first_row) begin
            below = '0;
        end else begin
            below = r_b1.col[0] ? t_err'(r_rd1) : t_err'(r_rd0);
        end
        s_w    = VW'({r_b1.sample, {FRAC_BITS{1'b0}}});
        c_w    = VW'(carry_in);
        b_w    = VW'(below);
        v      = s_w + c_w + b_w;
        dot_b1 = (v >= DOT_TH);
        ev     = dot_b1 ? v - FULL : v;
        e_b1   = sat(ev);
        carry_new = r_b1.last_col ? '0 : share(e_b1, W_RIGHT);
        n_carry = r_b1.frame_start ? '0 : r_carry;
        n_carry[r_b1.ch] = carry_new;
    end

    // stage 2: next-row shares and line-buffer writes
    always_comb begin
        p0_old = r_b2.frame_start ? '0 : t_err'(r_p0[r_b2.ch]);
        p1_old = r_b2.frame_start ? '0 : t_err'(r_p1[r_b2.ch]);
        e3     = share(r_b2_e, W_DIAG_L);
        e5     = share(r_b2_e, W_BELOW);
        e1     = share(r_b2_e, W_DIAG_R);
        wr_prev_data = sat(VW'(p0_old) + VW'(e3));
        np0          = sat(VW'(p1_old) + VW'(e5));
        n_p0 = r_b2.frame_start ? '0 : r_p0;
        n_p1 = r_b2.frame_start ? '0 : r_p1;
        if (r_b2.last_col) begin
            n_p0[r_b2.ch] = '0;
            n_p1[r_b2.ch] = '0;
        end else begin
            n_p0[r_b2.ch] = np0;
            n_p1[r_b2.ch] = e1;
        end

        do_b2   = adv && r_b2_vld;
        col_p   = r_b2.col - COL_W'(1);
        prev_en = (r_b2.col != '0);
        // below-left lands on col-1, row end also stores col itself
        if (prev_en && !col_p[0]) begin
            we0 = do_b2;
            wa0 = bank_addr(col_p, r_b2.ch);
            wd0 = wr_prev_data;
        end else begin
            we0 = do_b2 && r_b2.last_col && !r_b2.col[0];
            wa0 = bank_addr(r_b2.col, r_b2.ch);
            wd0 = np0;
        end
        if (prev_en && col_p[0]) begin
            we1 = do_b2;
            wa1 = bank_addr(col_p, r_b2.ch);
            wd1 = wr_prev_data;
        end else begin
            we1 = do_b2 && r_b2.last_col && r_b2.col[0];
            wa1 = bank_addr(r_b2.col, r_b2.ch);
            wd1 = np0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_vld  <= 1'b0;
            r_b2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_carry   <= '0;
            r_p0      <= '0;
            r_p1      <= '0;
        end else if (adv) begin
            r_b1_vld  <= take;
            r_b2_vld  <= r_b1_vld;
            r_out_vld <= r_b2_vld;
            if (r_b1_vld) r_carry <= n_carry;
            if (r_b2_vld) begin
                r_p0 <= n_p0;
                r_p1 <= n_p1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b1     <= i_q_op;
            r_b2     <= r_b1;
            r_b2_e   <= e_b1;
            r_b2_dot <= dot_b1;
            r_dot    <= r_b2_dot;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.dot   = r_dot;

    a_row_end_clears_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_b2_vld && r_b2.last_col
        |=> r_p0[$past(r_b2.ch)] == '0 && r_p1[$past(r_b2.ch)] == '0)
        else $error("pending next-row sums not cleared at row end");

    a_frame_clears_carry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_b1_vld && r_b1.frame_start && r_b1.last_col |=> r_carry == '0)
        else $error("right carries survive a frame start");

    a_no_stale_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && !i_q_op.first_row && r_b2_vld && r_b2.last_col && r_b2.ch == i_q_op.ch
        |-> r_b2.col != i_q_op.col)
        else $error("line buffer read overtakes its pending write");

endmodule

@@ dv/tb.sv @@
// Testbench for error_diffusion_halftone_core: streams raster sample beats in, checks every
// dot beat against a Floyd-Steinberg predictor kept inside the bench or a typed-in dot.
// Depends on ehd_pkg, ehd_if and the core RTL; needs nothing else.
module tb;
    import ehd_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 32;
    localparam int SMALL_ITEMS  = 330;      // random beats at small row sizes
    localparam int HOLD_CYCLES  = 400;      // long output hold-off to back the core up
    localparam int MAX_REPORTS  = 10;

    // Fixed-point constants: mid-grey 127.5 and full white, 8 fractional bits
    localparam int DOT_THRESHOLD = SAMPLE_MAX << (FRAC_BITS - 1);
    localparam int DOT_FULL      = SAMPLE_MAX << FRAC_BITS;
    localparam int ERR_HI        = (1 << (ERR_BITS - 1)) - 1;
    localparam int ERR_LO        = -(1 << (ERR_BITS - 1));

    localparam int DIRECTED_ROWS = 33;

    typedef enum logic {ROW_BEAT, ROW_REG} t_row_kind;
    typedef enum int {TONE_ANY, TONE_RAIL, TONE_MID, TONE_FLAT} t_tone;

    // One line of the directed table: a register write or a sample beat. Where the dot
    // is obvious (frame start, nothing diffused yet) it is typed in; else predicted.
    typedef struct packed {
        t_row_kind        kind;
        t_cfg_idx         reg_idx;
        logic [CFG_W-1:0] value;
        logic             fs;
        logic             known;
        logic             dot;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    ehd_in_if  in_if ();
    ehd_out_if out_if ();

    error_diffusion_halftone_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: line buffer of next-row errors, per-channel right
    // carries, and the two next-row sums still being built per channel.
    // ------------------------------------------------------------------
    logic signed [ERR_BITS-1:0] below_err [MAX_WIDTH*MAX_CHANNELS];
    logic signed [ERR_BITS-1:0] right_err [MAX_CHANNELS];
    logic signed [ERR_BITS-1:0] diag_err  [2*MAX_CHANNELS];
    int               pix_col;
    int               pix_ch;
    bit               top_row;
    logic [LW_W-1:0]  cfg_width;
    logic [NCH_W-1:0] cfg_chans;

    logic        dots_due [$];      // expected dots, oldest first
    int          dot_errors = 0;
    int unsigned cycle_cnt  = 0;

    // Stimulus shaping, changed per phase by the main sequence
    bit         calm;               // no idling on either side
    t_tone      tone;
    logic [7:0] flat_level;
    int         hold_left = 0;      // counted down by the dot sink
    t_row       directed_rows [DIRECTED_ROWS];

    function automatic int clip_err(input int x);
        if (x > ERR_HI) return ERR_HI;
        if (x < ERR_LO) return ERR_LO;
        return x;
    endfunction

    // Weighted share in sixteenths, floor rounding
    function automatic int portion(input int err, input logic [2:0] wt);
        return (err * int'(wt)) >>> SHARE_SHIFT;
    endfunction

    function automatic int width_eff(input int raw);
        if (raw < 1) return 1;
        if (raw > MAX_WIDTH) return MAX_WIDTH;
        return raw;
    endfunction

    function automatic int chans_eff(input int raw);
        if (raw < 1) return 1;
        if (raw > MAX_CHANNELS) return MAX_CHANNELS;
        return raw;
    endfunction

    function automatic void restart_frame();
        foreach (right_err[i]) right_err[i] = '0;
        foreach (diag_err[i]) diag_err[i] = '0;
        pix_col = 0;
        pix_ch  = 0;
        top_row = 1'b1;
    endfunction

    // Quantize one sample and push its error into the carries and line buffer
    function automatic logic halftone_dot(input logic [SAMPLE_W-1:0] s, input logic fs);
        int w, nch, col, ch, idx, v, e, below;
        bit last_col, last_ch, dot;
        w   = width_eff(cfg_width);
        nch = chans_eff(cfg_chans);
        if (fs) restart_frame();
        // A count at or past a limit that shrank mid-row is the last one
        col = (pix_col >= MAX_WIDTH) ? MAX_WIDTH - 1 : pix_col;
        ch  = (pix_ch >= MAX_CHANNELS) ? MAX_CHANNELS - 1 : pix_ch;
        last_col = (col + 1 >= w);
        last_ch  = (ch + 1 >= nch);
        idx = col * MAX_CHANNELS + ch;

        below = top_row ? 0 : below_err[idx];
        v   = (int'(s) << FRAC_BITS) + right_err[ch] + below;
        dot = (v >= DOT_THRESHOLD);
        e   = clip_err(dot ? v - DOT_FULL : v);

        // 3/16 goes below-left; nothing left of column 0
        if (col > 0)
            below_err[idx - MAX_CHANNELS] =
                ERR_BITS'(clip_err(diag_err[2*ch] + portion(e, W_DIAG_L)));
        diag_err[2*ch]   = ERR_BITS'(clip_err(diag_err[2*ch+1] + portion(e, W_BELOW)));
        diag_err[2*ch+1] = ERR_BITS'(portion(e, W_DIAG_R));

        if (last_col) begin
            // Right and below-right shares fall off the image
            below_err[idx]   = diag_err[2*ch];
            diag_err[2*ch]   = '0;
            diag_err[2*ch+1] = '0;
            right_err[ch]    = '0;
        end else begin
            right_err[ch] = ERR_BITS'(portion(e, W_RIGHT));
        end

        if (last_ch) begin
            pix_ch = 0;
            if (last_col) begin
                pix_col = 0;
                top_row = 1'b0;
            end else begin
                pix_col = col + 1;
            end
        end else begin
            pix_ch = ch + 1;
        end
        return dot;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] next_tone();
        int r;
        r = $urandom_range(0, 3);
        case (tone)
            TONE_RAIL: return r[1] ? 8'(SAMPLE_MAX - r[0]) : 8'(r[0]);
            TONE_MID:  return 8'($urandom_range(120, 135));
            TONE_FLAT: return flat_level;
            default:   return 8'($urandom);
        endcase
    endfunction

    task automatic report_miss(input string what, input logic want, input logic got);
        dot_errors++;
        if (dot_errors <= MAX_REPORTS)
            $display("cycle %0d: %s: expected dot %b, got %b", cycle_cnt, what, want, got);
    endtask

    // Offer one sample beat, hold it until taken, then record its dot
    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic fs,
                               input bit known, input logic known_dot);
        int   gap;
        logic dot;
        gap = calm ? 0 : idle_len();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.sample      <= s;
        in_if.frame_start <= fs;
        do @(posedge i_clk); while (!in_if.ready);
        dot = halftone_dot(s, fs);
        dots_due.push_back(known ? known_dot : dot);
    endtask

    // Register write: only once every dot due has come back
    task automatic write_reg(input t_cfg_idx idx, input int value);
        in_if.valid <= 1'b0;
        while (dots_due.size() != 0) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_LINE_WIDTH) cfg_width = LW_W'(value);
        else cfg_chans = NCH_W'(value);
        @(posedge i_clk);
    endtask

    // One phase: set geometry, then a run of beats; noisy phases scatter frame starts
    task automatic run_frames(input int w_raw, input int ch_raw, input int beats,
                              input bit fresh, input bit noisy, input bit squeeze);
        write_reg(REG_LINE_WIDTH, w_raw);
        write_reg(REG_CHANNELS, ch_raw);
        if (squeeze) hold_left = HOLD_CYCLES;
        for (int i = 0; i < beats; i++)
            send_sample(next_tone(), (i == 0 && fresh) || (noisy && $urandom_range(0, 39) == 0),
                        1'b0, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Dot sink: random stalls, plus the long hold-off when asked
    // ------------------------------------------------------------------
    initial begin : dot_sink
        int stall_left;
        stall_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                out_if.ready <= 1'b1;
                if (!calm) stall_left = idle_len();
            end
        end
    end

    // Every dot beat is matched with the oldest expectation
    always @(posedge i_clk) begin : dot_check
        logic want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (dots_due.size() == 0) begin
                report_miss("dot beat with none due", 1'bx, out_if.dot);
            end else begin
                want = dots_due.pop_front();
                if (out_if.dot !== want) report_miss("dot mismatch", want, out_if.dot);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int sent, w_raw, ch_raw, per_row, beats, r;
        bit fresh;

        in_if.valid       <= 1'b0;
        in_if.sample      <= '0;
        in_if.frame_start <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= REG_LINE_WIDTH;
        i_cfg_data        <= '0;
        i_rst_n           <= 1'b0;
        calm       = 1'b0;
        tone       = TONE_ANY;
        flat_level = '0;

        foreach (below_err[i]) below_err[i] = '0;
        cfg_width = LW_W'(LW_RESET);
        cfg_chans = NCH_W'(NCH_RESET);
        restart_frame();

        // Directed: rails and threshold at frame start, a 2x2-channel image over
        // two rows, frame start mid-row, zero registers acting as one, the widest
        // setting, and a row and pixel cut short by shrinking both registers.
        directed_rows = '{
            '{ROW_BEAT, REG_LINE_WIDTH, 255,  1'b1, 1'b1, 1'b1},
            '{ROW_BEAT, REG_LINE_WIDTH, 0,    1'b1, 1'b1, 1'b0},
            '{ROW_BEAT, REG_LINE_WIDTH, 128,  1'b1, 1'b1, 1'b1},
            '{ROW_BEAT, REG_LINE_WIDTH, 127,  1'b1, 1'b1, 1'b0},
            '{ROW_REG,  REG_LINE_WIDTH, 2,    1'b0, 1'b0, 1'b0},
            '{ROW_REG,  REG_CHANNELS,   2,    1'b0, 1'b0, 1'b0},
            '{ROW_BEAT, REG_LINE_WIDTH, 200,  1'b1, 1'b0, 1'b0},
            '{ROW_BEAT, REG_LINE_WIDTH, 60,   1'b0, 1'b0, 1'b0},
            '{ROW_BEAT, REG_LINE_WIDTH, 255,  1'b0, 1'b0, 1'b0},
            '{ROW_BEAT, REG_LINE_WIDTH, 0,    1'b0, 1'b0, 1'b0},
            '{ROW_BEAT, REG_LINE_WIDTH, 128,  1'b0, 1'b0, 1'b0},
            '{ROW_BEAT, REG_LINE_WIDTH, 127,  1'b0, 1'b0, 1'b0},
            '{ROW_BEAT, REG_LINE_WIDTH, 0,    1'b0, 1'b0, 1'b0},
            '{ROW_BEAT, REG_LINE_WIDTH, 255,  1'b0, 1'b0, 1'b0},
            '{ROW_BEAT, REG_LINE_WIDTH, 100,  1'b0, 1'b0, 1'b0},
            '{ROW_BEAT, REG_LINE_WIDTH, 0,    1'b1, 1'b1, 1'b0},
            '{ROW_REG,  REG_LINE_WIDTH, 0,    1'b0, 1'b0, 1'b0},
            '{ROW_REG,  REG_CHANNELS,   0,    1'b0, 1'b0, 1'b0},
            '{ROW_BEAT, REG_LINE_WIDTH, 130,  1'b1, 1'b1, 1'b1},
            '{ROW_BEAT, REG_LINE_WIDTH, 126,  1'b0, 1'b0, 1'b0},
            '{ROW_BEAT, REG_LINE_WIDTH, 255,  1'b0, 1'b0, 1'b0},
            '{ROW_BEAT, REG_LINE_WIDTH, 1,    1'b0, 1'b0, 1'b0},
            '{ROW_REG,  REG_LINE_WIDTH, 2047, 1'b0, 1'b0, 1'b0},
            '{ROW_REG,  REG_CHANNELS,   3,    1'b0, 1'b0, 1'b0},
            '{ROW_BEAT, REG_LINE_WIDTH, 255,  1'b1, 1'b1, 1'b1},
            '{ROW_BEAT, REG_LINE_WIDTH, 0,    1'b0, 1'b0, 1'b0},
            '{ROW_BEAT, REG_LINE_WIDTH, 127,  1'b0, 1'b0, 1'b0},
            '{ROW_BEAT, REG_LINE_WIDTH, 128,  1'b0, 1'b0, 1'b0},
            '{ROW_REG,  REG_LINE_WIDTH, 1,    1'b0, 1'b0, 1'b0},
            '{ROW_REG,  REG_CHANNELS,   1,    1'b0, 1'b0, 1'b0},
            '{ROW_BEAT, REG_LINE_WIDTH, 100,  1'b0, 1'b0, 1'b0},
            '{ROW_BEAT, REG_LINE_WIDTH, 200,  1'b0, 1'b0, 1'b0},
            '{ROW_BEAT, REG_LINE_WIDTH, 50,   1'b0, 1'b0, 1'b0}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_REG)
                write_reg(directed_rows[k].reg_idx, int'(directed_rows[k].value));
            else
                send_sample(directed_rows[k].value[SAMPLE_W-1:0], directed_rows[k].fs,
                            directed_rows[k].known, directed_rows[k].dot);
        end

        // Widest row, 3 channels then 1: the column count runs to its top and wraps
        run_frames(2047, MAX_CHANNELS, 48, 1'b1, 1'b0, 1'b0);
        run_frames(MAX_WIDTH, 1, MAX_WIDTH + 16, 1'b1, 1'b0, 1'b0);

        // Output held off for a long stretch while beats keep coming
        calm = 1'b1;
        run_frames(6, 3, 90, 1'b1, 1'b0, 1'b1);

        // Random phases: mostly whole frames of small images, some cut short,
        // some continued with the same or smaller geometry and no new frame
        sent = 0;
        while (sent < SMALL_ITEMS) begin
            calm       = ($urandom_range(0, 4) == 0);
            tone       = t_tone'($urandom_range(0, 3));
            flat_level = 8'($urandom);
            r = $urandom_range(0, 19);
            if (r == 0) w_raw = 0;
            else if (r == 1) w_raw = 1;
            else if (r == 2) w_raw = $urandom_range(9, 40);
            else w_raw = $urandom_range(1, 8);
            ch_raw  = $urandom_range(0, 3);
            per_row = width_eff(w_raw) * chans_eff(ch_raw);
            beats   = per_row * $urandom_range(1, 4);
            if ($urandom_range(0, 4) == 0) beats = $urandom_range(1, beats);
            else if ($urandom_range(0, 4) == 0) beats += $urandom_range(1, per_row);
            // A grown row would read line-buffer entries never written
            fresh = 1'b1;
            if (width_eff(w_raw) <= width_eff(cfg_width) &&
                chans_eff(ch_raw) <= chans_eff(cfg_chans))
                fresh = $urandom_range(0, 1);
            run_frames(w_raw, ch_raw, beats, fresh, $urandom_range(0, 5) == 0, 1'b0);
            sent += beats;
        end

        in_if.valid <= 1'b0;
        while (dots_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (dot_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
